// File: rtl/delay_sum_beam_response_core_defines.svh
// Assertion macros shared by the beam response core.
`ifndef DELAY_SUM_BEAM_RESPONSE_CORE_DEFINES_SVH
`define DELAY_SUM_BEAM_RESPONSE_CORE_DEFINES_SVH

// Same-cycle implication, checked on rising clk outside reset.
`define DSBR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on rising clk outside reset.
`define DSBR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/dsbr_pkg.sv
// Package with widths, codes, CORDIC tables and shared types of the beam response core.
package dsbr_pkg;

  localparam int MAX_ELEMENTS = 16;
  localparam int IDX_W        = $clog2(MAX_ELEMENTS);
  localparam int CNT_W        = 5;
  localparam int FREQ_W       = 15;
  localparam int COORD_W      = 16;
  localparam int DELAY_W      = 24;
  localparam int LEVEL_W      = 16;
  localparam int CFG_IDX_W    = 1;

  localparam int CORDIC_STEPS = 16;
  localparam int ATAN_ENTRIES = 24;
  localparam int CORDIC_W     = 34;
  localparam logic [31:0] CORDIC_GAIN = 32'h26DD3B6A;
  localparam logic [8:0]  SOUND_SPEED = 9'd343;
  // floor(2^32 / 343)
  localparam logic [23:0] SOUND_RECIP = 24'd12521770;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_EVAL  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_FREQ  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT = 1'b1;

  typedef struct packed {
    logic                        busy;
    logic signed [CORDIC_W-1:0]  cos_v;
    logic signed [CORDIC_W-1:0]  sin_v;
  } cor_stat_t;

  function automatic logic [31:0] atan_turns(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:    v = 32'h20000000;
      5'd1:    v = 32'h12E4051E;
      5'd2:    v = 32'h09FB385B;
      5'd3:    v = 32'h051111D4;
      5'd4:    v = 32'h028B0D43;
      5'd5:    v = 32'h0145D7E1;
      5'd6:    v = 32'h00A2F61E;
      5'd7:    v = 32'h00517C55;
      5'd8:    v = 32'h0028BE53;
      5'd9:    v = 32'h00145F2F;
      5'd10:   v = 32'h000A2F98;
      5'd11:   v = 32'h000517CC;
      5'd12:   v = 32'h00028BE6;
      5'd13:   v = 32'h000145F3;
      5'd14:   v = 32'h0000A2FA;
      5'd15:   v = 32'h0000517D;
      5'd16:   v = 32'h000028BE;
      5'd17:   v = 32'h0000145F;
      5'd18:   v = 32'h00000A30;
      5'd19:   v = 32'h00000518;
      5'd20:   v = 32'h0000028C;
      5'd21:   v = 32'h00000146;
      5'd22:   v = 32'h000000A3;
      5'd23:   v = 32'h00000051;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/dsbr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dsbr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/dsbr_cordic.sv
// Iterative CORDIC rotator: cosine and sine of a phase in turns, one step per cycle.
module dsbr_cordic (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [31:0]           phase,
  output dsbr_pkg::cor_stat_t   stat
);
  import dsbr_pkg::*;

  localparam logic signed [CORDIC_W-1:0] QUARTER = CORDIC_W'(64'sd1073741824);
  localparam logic signed [CORDIC_W-1:0] HALF    = CORDIC_W'(64'sd2147483648);

  logic                       run_r;
  logic [4:0]                 cnt_r;
  logic                       flip_r;
  logic signed [CORDIC_W-1:0] x_r, y_r, z_r;
  logic signed [CORDIC_W-1:0] z0, sx, sy, ang;

  always_comb begin
    z0  = {{(CORDIC_W-32){phase[31]}}, phase};
    sx  = x_r >>> cnt_r;
    sy  = y_r >>> cnt_r;
    ang = {{(CORDIC_W-32){1'b0}}, atan_turns(cnt_r)};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      cnt_r <= '0;
    end else if (start) begin
      run_r <= 1'b1;
      cnt_r <= '0;
    end else if (run_r) begin
      if (cnt_r == 5'(CORDIC_STEPS - 1)) begin
        run_r <= 1'b0;
      end
      cnt_r <= cnt_r + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r <= {{(CORDIC_W-32){1'b0}}, CORDIC_GAIN};
      y_r <= '0;
      // fold into a quarter turn either side of zero
      if (z0 > QUARTER) begin
        z_r    <= z0 - HALF;
        flip_r <= 1'b1;
      end else if (z0 < -QUARTER) begin
        z_r    <= z0 + HALF;
        flip_r <= 1'b1;
      end else begin
        z_r    <= z0;
        flip_r <= 1'b0;
      end
    end else if (run_r) begin
      if (!z_r[CORDIC_W-1]) begin
        x_r <= x_r - sy;
        y_r <= y_r + sx;
        z_r <= z_r - ang;
      end else begin
        x_r <= x_r + sy;
        y_r <= y_r - sx;
        z_r <= z_r + ang;
      end
    end
  end

  always_comb begin
    stat.busy  = run_r;
    stat.cos_v = flip_r ? -x_r : x_r;
    stat.sin_v = flip_r ? -y_r : y_r;
  end

endmodule

// File: rtl/delay_sum_beam_response_core.sv
// Top level of the delay-and-sum beam response core.
//
//  channel  ports                                  transaction
//  in       start/busy, in_*                       start high while busy low
//  out      out_valid, out_beam_level              one-cycle strobe
//  cfg      cfg_valid/cfg_ready, cfg_index/data    valid and ready high
//
// An element write gives no result. An evaluation of N elements raises the
// result strobe after these steps: per element a 24-step square root, a
// reciprocal multiply by the speed of sound with two one-step corrections and a
// 16-step CORDIC, the squarings and multiplies sharing one multiplier;
// the final magnitude reuses the square root, then a 24-step divide by N.
// An empty array answers in the next cycle. Reset is synchronous; table contents
// are not cleared. Results cannot be stalled: each appears for one cycle.
`include "delay_sum_beam_response_core_defines.svh"

module delay_sum_beam_response_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 in_operation,
  input  logic [dsbr_pkg::IDX_W-1:0]           in_element_index,
  input  logic signed [dsbr_pkg::COORD_W-1:0]  in_element_x,
  input  logic signed [dsbr_pkg::COORD_W-1:0]  in_element_y,
  input  logic [dsbr_pkg::DELAY_W-1:0]         in_element_delay,
  input  logic signed [dsbr_pkg::COORD_W-1:0]  in_point_x,
  input  logic signed [dsbr_pkg::COORD_W-1:0]  in_point_y,
  output logic                                 out_valid,
  output logic [dsbr_pkg::LEVEL_W-1:0]         out_beam_level,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [dsbr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [dsbr_pkg::FREQ_W-1:0]          cfg_data
);
  import dsbr_pkg::*;

  localparam int ENTRY_W = 2 * COORD_W + DELAY_W;

  typedef enum logic [21:0] {
    S_IDLE = 22'h000001,
    S_RD   = 22'h000002,
    S_LD   = 22'h000004,
    S_MX   = 22'h000008,
    S_MY   = 22'h000010,
    S_SQS  = 22'h000020,
    S_SQ   = 22'h000040,
    S_MF   = 22'h000080,
    S_MD   = 22'h000100,
    S_Q1   = 22'h000200,
    S_Q2   = 22'h000400,
    S_Q3   = 22'h000800,
    S_Q4   = 22'h001000,
    S_Q5   = 22'h002000,
    S_Q6   = 22'h004000,
    S_CS   = 22'h008000,
    S_COR  = 22'h010000,
    S_FX   = 22'h020000,
    S_FY   = 22'h040000,
    S_FSQS = 22'h080000,
    S_FSQ  = 22'h100000,
    S_DIV  = 22'h200000
  } state_t;

  state_t state_r, state_nxt;

  logic [FREQ_W-1:0] freq_r;
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  n_eff;
  logic [CNT_W-1:0]  n_r, idx_r;
  logic              busy_r;
  logic              out_valid_r;
  logic [LEVEL_W-1:0] level_r;
  logic              accept;

  logic signed [COORD_W-1:0] px_r, py_r;
  logic signed [COORD_W:0]   dx_r, dy_r;
  logic [DELAY_W-1:0]        dly_r;
  logic [ENTRY_W-1:0]        rdata;

  logic signed [32:0] mul_a;
  logic signed [25:0] mul_b;
  logic               mul_en;
  logic signed [58:0] prod_r;
  logic [47:0]        acc_r;

  logic signed [39:0] re_r, im_r;
  logic signed [25:0] re_s, im_s;

  // division by the speed of sound through the reciprocal
  logic [31:0] num_r, frac_r;
  logic [23:0] dterm_r;
  logic [11:0] q_r;
  logic [8:0]  r_r;
  logic [19:0] b_r, b_fix;
  logic [9:0]  rem_a, rem_b;

  // square root unit
  logic        sq_start;
  logic [47:0] sq_in, sq_n_r, sq_r_r, sq_b_r, sq_t;
  // divider unit
  logic        dv_start;
  logic [23:0] dv_dvd_r, dv_quo_r;
  logic [4:0]  dv_dvs_r, dv_rem_r, dv_cnt_r;
  logic [5:0]  dv_t;

  logic        cor_start;
  logic [31:0] phase;
  cor_stat_t   cor_stat;

  assign accept    = start && !busy_r;
  assign busy      = busy_r;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_beam_level = level_r;
  assign n_eff = (count_r > CNT_W'(MAX_ELEMENTS)) ? CNT_W'(MAX_ELEMENTS) : count_r;
  assign re_s  = re_r[39:14];
  assign im_s  = im_r[39:14];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      freq_r  <= FREQ_W'(1000);
      count_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FREQ:  freq_r  <= cfg_data;
        REG_COUNT: count_r <= cfg_data[CNT_W-1:0];
        default:   ;
      endcase
    end
  end

  dsbr_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_ELEMENTS)) u_table (
    .clk   (clk),
    .we    (accept && in_operation == OP_WRITE),
    .waddr (in_element_index),
    .wdata ({in_element_x, in_element_y, in_element_delay}),
    .raddr (idx_r[IDX_W-1:0]),
    .rdata (rdata)
  );

  // shared multiplier operand select
  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    case (state_r)
      S_MX: begin
        mul_a = 33'(dx_r);
        mul_b = 26'(dx_r);
      end
      S_MY: begin
        mul_a = 33'(dy_r);
        mul_b = 26'(dy_r);
      end
      S_MF: begin
        mul_a = {18'd0, freq_r};
        mul_b = {2'd0, sq_r_r[23:0]};
      end
      S_MD: begin
        mul_a = {18'd0, freq_r};
        mul_b = {2'd0, dly_r};
      end
      S_Q1: begin
        mul_a = {1'b0, num_r};
        mul_b = {2'd0, SOUND_RECIP};
      end
      S_Q2: begin
        mul_a = {9'd0, prod_r[55:32]};
        mul_b = {17'd0, SOUND_SPEED};
      end
      S_Q4: begin
        mul_a = {24'd0, r_r};
        mul_b = {2'd0, SOUND_RECIP};
      end
      S_Q5: begin
        mul_a = {13'd0, prod_r[31:12]};
        mul_b = {17'd0, SOUND_SPEED};
      end
      S_FX: begin
        mul_a = 33'(re_s);
        mul_b = re_s;
      end
      S_FY: begin
        mul_a = 33'(im_s);
        mul_b = im_s;
      end
      default: mul_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod_r <= mul_a * mul_b;
    end
  end

  // remainders of the two quotient estimates are below 686, so ten bits hold them
  assign rem_a = num_r[9:0] - prod_r[9:0];
  assign rem_b = 10'd0 - prod_r[9:0];
  assign b_fix = b_r + 20'(rem_b >= {1'b0, SOUND_SPEED});

  // square root, one result bit per cycle
  assign sq_t = sq_r_r + sq_b_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_b_r <= '0;
    end else if (sq_start) begin
      sq_b_r <= 48'h4000_0000_0000;
    end else if (sq_b_r != '0) begin
      sq_b_r <= sq_b_r >> 2;
    end
  end
  always_ff @(posedge clk) begin
    if (sq_start) begin
      sq_n_r <= sq_in;
      sq_r_r <= '0;
    end else if (sq_b_r != '0) begin
      if (sq_n_r >= sq_t) begin
        sq_n_r <= sq_n_r - sq_t;
        sq_r_r <= (sq_r_r >> 1) + sq_b_r;
      end else begin
        sq_r_r <= sq_r_r >> 1;
      end
    end
  end

  // restoring divider by the element count, one quotient bit per cycle
  assign dv_t = {dv_rem_r, dv_dvd_r[23]};
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_cnt_r <= '0;
    end else if (dv_start) begin
      dv_cnt_r <= 5'd24;
    end else if (dv_cnt_r != '0) begin
      dv_cnt_r <= dv_cnt_r - 5'd1;
    end
  end
  always_ff @(posedge clk) begin
    if (dv_start) begin
      dv_dvd_r <= sq_r_r[23:0];
      dv_dvs_r <= n_r;
      dv_rem_r <= '0;
      dv_quo_r <= '0;
    end else if (dv_cnt_r != '0) begin
      dv_dvd_r <= dv_dvd_r << 1;
      if (dv_t >= {1'b0, dv_dvs_r}) begin
        dv_rem_r <= 5'(dv_t - {1'b0, dv_dvs_r});
        dv_quo_r <= {dv_quo_r[22:0], 1'b1};
      end else begin
        dv_rem_r <= dv_t[4:0];
        dv_quo_r <= {dv_quo_r[22:0], 1'b0};
      end
    end
  end

  assign phase = frac_r + {dterm_r, 8'd0};

  dsbr_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cor_start),
    .phase (phase),
    .stat  (cor_stat)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    sq_start  = 1'b0;
    sq_in     = acc_r + prod_r[47:0];
    dv_start  = 1'b0;
    cor_start = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept && in_operation == OP_EVAL && n_eff != '0) begin
          state_nxt = S_RD;
        end
      end
      S_RD:   state_nxt = S_LD;
      S_LD:   state_nxt = S_MX;
      S_MX:   state_nxt = S_MY;
      S_MY:   state_nxt = S_SQS;
      S_SQS: begin
        sq_start  = 1'b1;
        state_nxt = S_SQ;
      end
      S_SQ: begin
        if (sq_b_r == '0) begin
          state_nxt = S_MF;
        end
      end
      S_MF:   state_nxt = S_MD;
      S_MD:   state_nxt = S_Q1;
      S_Q1:   state_nxt = S_Q2;
      S_Q2:   state_nxt = S_Q3;
      S_Q3:   state_nxt = S_Q4;
      S_Q4:   state_nxt = S_Q5;
      S_Q5:   state_nxt = S_Q6;
      S_Q6:   state_nxt = S_CS;
      S_CS: begin
        cor_start = 1'b1;
        state_nxt = S_COR;
      end
      S_COR: begin
        if (!cor_stat.busy) begin
          state_nxt = (idx_r + CNT_W'(1) == n_r) ? S_FX : S_RD;
        end
      end
      S_FX:   state_nxt = S_FY;
      S_FY:   state_nxt = S_FSQS;
      S_FSQS: begin
        sq_start  = 1'b1;
        state_nxt = S_FSQ;
      end
      S_FSQ: begin
        if (sq_b_r == '0) begin
          dv_start  = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (dv_cnt_r == '0) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (accept && in_operation == OP_EVAL) begin
            if (n_eff == '0) begin
              out_valid_r <= 1'b1;
            end else begin
              busy_r  <= 1'b1;
              idx_r   <= '0;
            end
          end
        end
        S_COR: begin
          if (!cor_stat.busy) begin
            idx_r <= idx_r + CNT_W'(1);
          end
        end
        S_DIV: begin
          if (dv_cnt_r == '0) begin
            out_valid_r <= 1'b1;
            busy_r      <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        px_r    <= in_point_x;
        py_r    <= in_point_y;
        n_r     <= n_eff;
        re_r    <= '0;
        im_r    <= '0;
        level_r <= '0;
      end
      S_LD: begin
        dx_r  <= 17'(px_r) - 17'(signed'(rdata[ENTRY_W-1 -: COORD_W]));
        dy_r  <= 17'(py_r) - 17'(signed'(rdata[DELAY_W +: COORD_W]));
        dly_r <= rdata[DELAY_W-1:0];
      end
      S_MY:   acc_r <= prod_r[47:0];
      S_MD:   num_r <= prod_r[31:0];
      S_Q1:   dterm_r <= prod_r[23:0];
      S_Q2:   q_r <= prod_r[43:32];
      S_Q3: begin
        // the estimate is low by at most one
        if (rem_a >= {1'b0, SOUND_SPEED}) begin
          q_r <= q_r + 12'd1;
          r_r <= 9'(rem_a - {1'b0, SOUND_SPEED});
        end else begin
          r_r <= rem_a[8:0];
        end
      end
      S_Q5:   b_r <= prod_r[31:12];
      S_Q6:   frac_r <= {q_r, b_fix};
      S_FY:   acc_r <= prod_r[47:0];
      S_COR: begin
        if (!cor_stat.busy) begin
          re_r <= re_r + 40'(cor_stat.cos_v);
          im_r <= im_r + 40'(cor_stat.sin_v);
        end
      end
      S_DIV: begin
        // saturate the normalized level
        if (dv_cnt_r == '0) begin
          level_r <= (dv_quo_r[23:16] != '0) ? '1 : dv_quo_r[15:0];
        end
      end
      default: ;
    endcase
  end

  `DSBR_ASSERT_NOW(a_out_not_busy, out_valid, !busy, "result strobe while still busy")
  `DSBR_ASSERT_NEXT(a_write_silent, accept && in_operation == OP_WRITE, !out_valid,
                    "element write produced a result")
  `DSBR_ASSERT_NEXT(a_empty_zero, accept && in_operation == OP_EVAL && n_eff == '0,
                    out_valid && out_beam_level == '0, "empty array must give level zero")
  `DSBR_ASSERT_NOW(a_units_exclusive, cor_stat.busy, sq_b_r == '0 && dv_cnt_r == '0,
                   "CORDIC overlaps another shared unit")

endmodule

// File: bench/tb_delay_sum_beam_response_core.sv
// Self-checking bench for the delay-and-sum beam response core.
module tb_delay_sum_beam_response_core;
  timeunit 1ns;
  timeprecision 1ps;
  import dsbr_pkg::*;

  typedef struct {
    logic                      op;
    logic [IDX_W-1:0]          idx;
    logic signed [COORD_W-1:0] ex;
    logic signed [COORD_W-1:0] ey;
    logic [DELAY_W-1:0]        dly;
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
  } beam_item_t;

  localparam longint ARC_TURNS [ATAN_ENTRIES] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
    64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D, 64'h000028BE, 64'h0000145F,
    64'h00000A30, 64'h00000518, 64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
  };
  localparam int CYCLE_LIMIT = 4000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_operation = OP_WRITE;
  logic [IDX_W-1:0] in_element_index = '0;
  logic signed [COORD_W-1:0] in_element_x = '0;
  logic signed [COORD_W-1:0] in_element_y = '0;
  logic [DELAY_W-1:0] in_element_delay = '0;
  logic signed [COORD_W-1:0] in_point_x = '0;
  logic signed [COORD_W-1:0] in_point_y = '0;
  logic out_valid;
  logic [LEVEL_W-1:0] out_beam_level;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_FREQ;
  logic [FREQ_W-1:0] cfg_data = '0;

  delay_sum_beam_response_core uut (.*);

  // mirror of the block state
  logic [FREQ_W-1:0] freq_hz = 15'd1000;
  logic [CNT_W-1:0] elem_count = '0;
  logic signed [COORD_W-1:0] x_tab [MAX_ELEMENTS];
  logic signed [COORD_W-1:0] y_tab [MAX_ELEMENTS];
  logic [DELAY_W-1:0] dly_tab [MAX_ELEMENTS];

  beam_item_t pending_items[$];
  logic [LEVEL_W-1:0] expected_levels[$];
  int failures = 0;
  int evals_sent = 0, writes_sent = 0, levels_seen = 0;
  int idle_gap = 0;
  bit quiet = 0;
  int cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic longint unsigned floor_sqrt(input longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic void cos_sin_turns(input logic [31:0] ph, output longint c,
                                        output longint s);
    longint z, x, y, t;
    bit flip;
    z = longint'($signed(ph));
    x = longint'(CORDIC_GAIN);
    y = 0;
    flip = 0;
    if (z > 64'sd1073741824) begin
      z -= 64'sd2147483648;
      flip = 1;
    end else if (z < -64'sd1073741824) begin
      z += 64'sd2147483648;
      flip = 1;
    end
    for (int i = 0; i < CORDIC_STEPS && i < ATAN_ENTRIES; i++) begin
      if (z >= 0) begin
        t = x - (y >>> i);
        y = y + (x >>> i);
        z -= ARC_TURNS[i];
      end else begin
        t = x + (y >>> i);
        y = y - (x >>> i);
        z += ARC_TURNS[i];
      end
      x = t;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic logic [LEVEL_W-1:0] beam_level_at(input logic signed [COORD_W-1:0] px,
                                                       input logic signed [COORD_W-1:0] py);
    longint unsigned n, f, d, ph, mag, lvl;
    longint re, im, c, s, dx, dy;
    n = (elem_count > MAX_ELEMENTS) ? MAX_ELEMENTS : elem_count;
    if (n == 0) return '0;
    f = freq_hz;
    re = 0;
    im = 0;
    for (int i = 0; i < n; i++) begin
      dx = longint'(px) - longint'(x_tab[i]);
      dy = longint'(py) - longint'(y_tab[i]);
      d = floor_sqrt(longint'(dx * dx + dy * dy));
      ph = ((f * d) << 20) / 343;
      ph += (f * longint'(dly_tab[i])) << 8;
      cos_sin_turns(ph[31:0], c, s);
      re += c;
      im += s;
    end
    re = re >>> 14;
    im = im >>> 14;
    mag = floor_sqrt(re * re + im * im);
    lvl = mag / n;
    if (lvl > 65535) lvl = 65535;
    return lvl[15:0];
  endfunction

  // driver: predict on each accepted transaction, then present the next item
  always @(posedge clk) begin
    beam_item_t it;
    if (rst_n) begin
      if (start && !busy) begin
        if (in_operation == OP_WRITE) begin
          x_tab[in_element_index] = in_element_x;
          y_tab[in_element_index] = in_element_y;
          dly_tab[in_element_index] = in_element_delay;
          writes_sent++;
        end else begin
          expected_levels.push_back(beam_level_at(in_point_x, in_point_y));
          evals_sent++;
        end
      end
      if (start && busy) begin
        // hold the item until accepted
      end else if (idle_gap > 0) begin
        idle_gap--;
        start <= 1'b0;
      end else if (!quiet && pending_items.size() > 0 && $urandom_range(0, 11) == 0) begin
        idle_gap = $urandom_range(0, 14);
        start <= 1'b0;
      end else if (pending_items.size() > 0) begin
        it = pending_items.pop_front();
        start <= 1'b1;
        in_operation <= it.op;
        in_element_index <= it.idx;
        in_element_x <= it.ex;
        in_element_y <= it.ey;
        in_element_delay <= it.dly;
        in_point_x <= it.px;
        in_point_y <= it.py;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: results cannot be stalled, check each strobe
  always @(posedge clk) begin
    logic [LEVEL_W-1:0] want;
    if (rst_n && out_valid) begin
      levels_seen++;
      if (expected_levels.size() == 0) begin
        $display("%0t: unexpected result beam_level=%0d", $time, out_beam_level);
        failures++;
      end else begin
        want = expected_levels.pop_front();
        if (want !== out_beam_level) begin
          $display("%0t: beam_level expected %0d actual %0d", $time, want, out_beam_level);
          failures++;
        end
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [FREQ_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    if (idx == REG_FREQ) freq_hz = val;
    else elem_count = val[CNT_W-1:0];
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (pending_items.size() > 0 || start || busy || expected_levels.size() > 0);
    repeat (10) @(posedge clk);
  endtask

  function automatic beam_item_t rand_item(input bit eval);
    beam_item_t it;
    it.op = eval ? OP_EVAL : OP_WRITE;
    it.idx = IDX_W'($urandom_range(0, MAX_ELEMENTS - 1));
    it.ex = 16'($urandom);
    it.ey = 16'($urandom);
    it.dly = 24'($urandom);
    it.px = 16'($urandom);
    it.py = 16'($urandom);
    // keep some geometry compact so the response is not pure noise
    if ($urandom_range(0, 2) == 0) begin
      it.ex = $signed(16'($urandom_range(0, 4095))) - 16'sd2048;
      it.ey = $signed(16'($urandom_range(0, 4095))) - 16'sd2048;
      it.dly = 24'($urandom_range(0, 255));
      it.px = $signed(16'($urandom_range(0, 8191))) - 16'sd4096;
      it.py = $signed(16'($urandom_range(0, 8191))) - 16'sd4096;
    end
    return it;
  endfunction

  function automatic beam_item_t make_item(input logic op, input int idx,
                                           input logic signed [15:0] ex, ey,
                                           input logic [23:0] dly,
                                           input logic signed [15:0] px, py);
    beam_item_t it;
    it.op = op; it.idx = IDX_W'(idx); it.ex = ex; it.ey = ey; it.dly = dly;
    it.px = px; it.py = py;
    return it;
  endfunction

  initial begin
    int nitems, fsel, csel;
    logic [FREQ_W-1:0] fval;
    logic [FREQ_W-1:0] cval;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty array, then fill every slot with extreme entries
    pending_items.push_back(make_item(OP_EVAL, 0, 0, 0, 0, 16'sh7FFF, -16'sh8000));
    for (int i = 0; i < MAX_ELEMENTS; i++)
      pending_items.push_back(make_item(OP_WRITE, i,
        (i % 3 == 0) ? -16'sh8000 : (i % 3 == 1) ? 16'sh7FFF : 16'sh0000,
        (i % 2 == 0) ? 16'sh7FFF : -16'sh8000,
        (i % 2 == 0) ? 24'hFFFFFF : 24'h000000, 16'shFFFF, 16'sh0000));
    wait_idle();
    write_reg(REG_COUNT, 15'd31);  // above table size, clamps to full array
    write_reg(REG_FREQ, 15'd32767);
    pending_items.push_back(make_item(OP_EVAL, 15, 0, 0, 0, -16'sh8000, -16'sh8000));
    pending_items.push_back(make_item(OP_EVAL, 0, 0, 0, 0, 16'sh7FFF, 16'sh7FFF));
    pending_items.push_back(make_item(OP_EVAL, 0, 0, 0, 0, 16'sh0000, 16'sh0000));
    wait_idle();
    write_reg(REG_FREQ, 15'd0);
    write_reg(REG_COUNT, 15'd1);
    pending_items.push_back(make_item(OP_EVAL, 0, 0, 0, 0, 16'sh1234, -16'sh0567));
    wait_idle();

    // random phases: new settings, then writes mixed with evaluations
    for (int p = 0; p < 22; p++) begin
      fsel = $urandom_range(0, 7);
      fval = (fsel == 0) ? 15'd0 : (fsel == 1) ? 15'd24000 : (fsel == 2) ? 15'd32767 :
             (fsel == 3) ? 15'd1 : 15'($urandom_range(0, 24000));
      csel = $urandom_range(0, 9);
      cval = (csel == 0) ? 15'd0 : (csel == 1) ? 15'd16 : (csel == 2) ?
             15'($urandom_range(17, 31)) : (csel == 3) ? 15'($urandom) :
             15'($urandom_range(1, 8));
      write_reg(REG_FREQ, fval);
      write_reg(REG_COUNT, cval);
      quiet = (p >= 20);
      nitems = $urandom_range(30, 45);
      for (int k = 0; k < nitems; k++)
        pending_items.push_back(rand_item($urandom_range(0, 1)));
      wait_idle();
    end

    repeat (50) @(posedge clk);
    if (expected_levels.size() > 0) begin
      $display("%0d expected results never arrived", expected_levels.size());
      failures++;
    end
    $display("covered %0d element writes and %0d evaluations, %0d levels checked",
             writes_sent, evals_sent, levels_seen);
    $display("over 25 register settings incl. empty, clamped count and frequency extremes");
    if (failures == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
